// ===== src/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// shared defaults and types for the sorted table binary search block
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int STS_TABLE_DEPTH = 16;
    localparam int STS_KEY_WIDTH   = 32;

    // queue fill status seen by the front and the back
    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage

// ===== src/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// closed-interval binary search over a table of ascending keys
//
//   channel   signals                                   direction
//   input     in_valid, in_stall, func, entry_index,    in (in_stall out)
//             key_value
//   output    out_valid, out_stall, found, match_index, out (out_stall in)
//             left_bound, right_bound
//   config    cfg_we, cfg_wdata (entries_in_use)        in
//
// a write word goes to the table ram as the back pops it; a search makes p probes,
// where p <= floor(log2(entries)) + 1, each probe a read of the table ram with
// registered output followed by a compare
// reset clears the count and control; table contents are undefined until written
// a two-word queue lets the input run ahead of a stalled search or result
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = sts_pkg::STS_TABLE_DEPTH,
    parameter int KEY_WIDTH   = sts_pkg::STS_KEY_WIDTH,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CNT_W-1:0]        cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    func,
    input  logic [IDX_W-1:0]        entry_index,
    input  logic [KEY_WIDTH-1:0]    key_value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    found,
    output logic [IDX_W-1:0]        match_index,
    output logic [CNT_W-1:0]        left_bound,
    output logic signed [CNT_W-1:0] right_bound
);

    import sts_pkg::*;

    localparam int Q_W = IDX_W + KEY_WIDTH + 1;

    q_status_t            q_status;
    logic                 q_push;
    logic                 q_pop;
    logic [Q_W-1:0]       q_push_data;
    logic [Q_W-1:0]       q_pop_data;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;

    sts_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .IDX_W       (IDX_W)
    ) u_front (
        .func        (func),
        .entry_index (entry_index),
        .key_value   (key_value),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_data      (q_push_data)
    );

    sts_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    sts_ram #(
        .WIDTH  (KEY_WIDTH),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sts_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_status    (q_status),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .match_index (match_index),
        .left_bound  (left_bound),
        .right_bound (right_bound)
    );

endmodule

// ===== src/sts_ram.sv =====
// ----------------------------------------------------------------------------
// sts_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sts_queue.sv =====
// ----------------------------------------------------------------------------
// sts_queue
// two-entry word queue between the front and the back
// ----------------------------------------------------------------------------
module sts_queue #(
    parameter int WIDTH = 37
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output sts_pkg::q_status_t status
);

    import sts_pkg::*;

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             do_push;
    logic             do_pop;

    assign status.full      = (cnt_reg == 2'd2);
    assign status.not_empty = (cnt_reg != 2'd0);
    assign do_push          = push && !status.full;
    assign do_pop           = pop && status.not_empty;
    assign pop_data         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/sts_front.sv =====
// ----------------------------------------------------------------------------
// sts_front
// input side: accepts words, drops out-of-range writes, queues the rest
// ----------------------------------------------------------------------------
module sts_front #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int IDX_W       = 4
) (
    input  logic                         func,
    input  logic [IDX_W-1:0]             entry_index,
    input  logic [KEY_WIDTH-1:0]         key_value,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  sts_pkg::q_status_t           q_status,
    output logic                         q_push,
    output logic [IDX_W+KEY_WIDTH:0]     q_data
);

    import sts_pkg::*;

    logic idx_in_range;

    assign idx_in_range = (IDX_W + 1)'(entry_index) < (IDX_W + 1)'(TABLE_DEPTH);
    assign in_stall     = q_status.full;
    // a write past the table end is taken and dropped
    assign q_push       = in_valid && !q_status.full && (func || idx_in_range);
    assign q_data       = {func, entry_index, key_value};

endmodule

// ===== src/sts_back.sv =====
// ----------------------------------------------------------------------------
// sts_back
// table writes, binary search sequencer, count register and result register
// ----------------------------------------------------------------------------
module sts_back #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CNT_W-1:0]            cfg_wdata,
    input  sts_pkg::q_status_t          q_status,
    input  logic [IDX_W+KEY_WIDTH:0]    q_data,
    output logic                        q_pop,
    output logic                        ram_we,
    output logic [IDX_W-1:0]            ram_waddr,
    output logic [KEY_WIDTH-1:0]        ram_wdata,
    output logic [IDX_W-1:0]            ram_raddr,
    input  logic [KEY_WIDTH-1:0]        ram_rdata,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic [IDX_W-1:0]            match_index,
    output logic [CNT_W-1:0]            left_bound,
    output logic signed [CNT_W-1:0]     right_bound
);

    import sts_pkg::*;

    localparam int BND_W = CNT_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [KEY_WIDTH-1:0]    key_reg;
    logic signed [BND_W-1:0] left_reg;
    logic signed [BND_W-1:0] left_next;
    logic signed [BND_W-1:0] right_reg;
    logic signed [BND_W-1:0] right_next;
    logic [IDX_W-1:0]        mid_reg;
    logic                    hit_reg;
    logic                    hit_next;
    logic                    out_valid_reg;
    logic                    found_reg;
    logic [IDX_W-1:0]        match_reg;
    logic [CNT_W-1:0]        left_out_reg;
    logic [CNT_W-1:0]        right_out_reg;

    logic                    q_func;
    logic [IDX_W-1:0]        q_idx;
    logic [KEY_WIDTH-1:0]    q_key;
    logic [CNT_W-1:0]        count_clamped;
    logic signed [BND_W-1:0] count_m1;
    logic signed [BND_W-1:0] span;
    logic signed [BND_W-1:0] mid_full;
    logic signed [BND_W-1:0] mid_ext;
    logic                    out_free;
    logic                    load_out;

    assign {q_func, q_idx, q_key} = q_data;

    assign count_clamped = (count_reg > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_reg;
    assign count_m1      = signed'({1'b0, count_clamped}) - BND_W'(1);
    assign span          = right_reg - left_reg;
    assign mid_full      = left_reg + (span >>> 1);
    assign mid_ext       = signed'({{(BND_W - IDX_W){1'b0}}, mid_reg});

    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == ST_DONE) && out_free;
    assign q_pop     = (state_reg == ST_IDLE) && q_status.not_empty;

    assign ram_we    = q_pop && !q_func;
    assign ram_waddr = q_idx;
    assign ram_wdata = q_key;
    assign ram_raddr = mid_full[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        right_next = right_reg;
        hit_next   = hit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && q_func)
                begin
                    left_next  = '0;
                    right_next = count_m1;
                    hit_next   = 1'b0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // the probe address goes out here, data is back next cycle
                state_next = (left_reg <= right_reg) ? ST_CMP : ST_DONE;
            end
            ST_CMP:
            begin
                priority if (ram_rdata == key_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (ram_rdata < key_reg)
                begin
                    left_next  = mid_ext + BND_W'(1);
                    state_next = ST_READ;
                end
                else
                begin
                    right_next = mid_ext - BND_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        hit_reg   <= hit_next;
        if (q_pop)
        begin
            key_reg <= q_key;
        end
        if (state_reg == ST_READ)
        begin
            mid_reg <= mid_full[IDX_W-1:0];
        end
        if (load_out)
        begin
            found_reg     <= hit_reg;
            match_reg     <= hit_reg ? mid_reg : '0;
            left_out_reg  <= left_reg[CNT_W-1:0];
            right_out_reg <= right_reg[CNT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_index = match_reg;
    assign left_bound  = left_out_reg;
    assign right_bound = signed'(right_out_reg);

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for sorted_table_binary_search: loads ascending, narrow
// (duplicate-heavy) and unordered tables, and checks every search answer
// against an in-bench binary search. Sender gaps and receiver stalls are
// random and run through several phases, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import sts_pkg::*;

    localparam int IDX_W        = $clog2(STS_TABLE_DEPTH);
    localparam int CNT_W        = $clog2(STS_TABLE_DEPTH + 1);
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;

    typedef enum logic {OP_WRITE = 1'b0, OP_SEARCH = 1'b1} op_e;

    typedef struct packed {
        logic                    found;
        logic [IDX_W-1:0]        match_index;
        logic [CNT_W-1:0]        left_bound;
        logic [CNT_W-1:0]        right_bound;
    } answer_t;

    class search_checker;
        logic [STS_KEY_WIDTH-1:0] keys [STS_TABLE_DEPTH];
        logic [CNT_W-1:0]         entries;
        answer_t                  pending_answers [$];
        int                       errors;

        function new();
            entries = '0;
            errors  = 0;
            for (int i = 0; i < STS_TABLE_DEPTH; i++)
                keys[i] = '0;
        endfunction

        // closed interval, lower midpoint, stop on first equal probe
        function answer_t bsearch_answer(logic [STS_KEY_WIDTH-1:0] target);
            answer_t a;
            int lo, hi, mid, n;
            n  = (entries > STS_TABLE_DEPTH) ? STS_TABLE_DEPTH : entries;
            lo = 0;
            hi = n - 1;
            a  = '0;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (keys[mid] == target)
                begin
                    a.found       = 1'b1;
                    a.match_index = mid[IDX_W-1:0];
                    break;
                end
                else if (keys[mid] < target)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
            a.left_bound  = lo[CNT_W-1:0];
            a.right_bound = hi[CNT_W-1:0];
            return a;
        endfunction

        function void note_word(op_e op, logic [IDX_W-1:0] idx,
                                logic [STS_KEY_WIDTH-1:0] key);
            if (op == OP_WRITE)
                keys[idx] = key;
            else
                pending_answers.push_back(bsearch_answer(key));
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            if (pending_answers.size() == 0)
            begin
                $display("%0t result word with none pending: expected none actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            compare_field("found", 32'(want.found), 32'(got.found));
            compare_field("match_index", 32'(want.match_index), 32'(got.match_index));
            compare_field("left_bound", 32'(want.left_bound), 32'(got.left_bound));
            compare_field("right_bound", 32'(want.right_bound), 32'(got.right_bound));
        endfunction
    endclass

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      cfg_we      = 1'b0;
    logic [CNT_W-1:0]          cfg_wdata   = '0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic                      func        = 1'b0;
    logic [IDX_W-1:0]          entry_index = '0;
    logic [STS_KEY_WIDTH-1:0]  key_value   = '0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic                      found;
    logic [IDX_W-1:0]          match_index;
    logic [CNT_W-1:0]          left_bound;
    logic signed [CNT_W-1:0]   right_bound;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_rx        = 1'b0;

    search_checker sb = new();

    logic [STS_KEY_WIDTH-1:0] seed_keys [STS_TABLE_DEPTH] = '{
        32'h0000_0010, 32'h0000_0020, 32'h0000_0020, 32'h0000_0020,
        32'h0000_0100, 32'h0000_1000, 32'h0000_8000, 32'h0001_0000,
        32'h0010_0000, 32'h0100_0000, 32'h1000_0000, 32'h7FFF_FFFF,
        32'h8000_0000, 32'hAAAA_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF
    };

    sorted_table_binary_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .entry_index (entry_index),
        .key_value   (key_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .match_index (match_index),
        .left_bound  (left_bound),
        .right_bound (right_bound)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
        out_stall <= hold_rx || ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_answer({found, match_index, left_bound, right_bound});

    task automatic send_word(op_e op, logic [IDX_W-1:0] idx, logic [STS_KEY_WIDTH-1:0] key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        func        = op;
        entry_index = idx;
        key_value   = key;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(op, idx, key);
        @(negedge clk);
    endtask

    // wait out every answer, then let trailing table writes retire
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_entries(logic [CNT_W-1:0] n);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = n;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.entries = n;
    endtask

    task automatic load_sorted(int unsigned max_step);
        logic [STS_KEY_WIDTH-1:0] v [STS_TABLE_DEPTH];
        logic [STS_KEY_WIDTH-1:0] lift;
        int unsigned pick;
        v[0] = $urandom_range(max_step);
        for (int i = 1; i < STS_TABLE_DEPTH; i++)
            v[i] = v[i-1] + $urandom_range(max_step);
        // on some loads shift the whole table up so the top bits get exercised too
        pick = $urandom_range(3);
        lift = '0;
        if (pick == 0)
            lift = 32'hFFFF_FFFF - v[STS_TABLE_DEPTH-1];
        else if (pick == 1)
            lift = $urandom_range(32'hFFFF_FFFF - v[STS_TABLE_DEPTH-1]);
        for (int i = 0; i < STS_TABLE_DEPTH; i++)
            send_word(OP_WRITE, IDX_W'(i), v[i] + lift);
    endtask

    function automatic logic [STS_KEY_WIDTH-1:0] pick_key(int n);
        int unsigned r;
        int unsigned k;
        r = $urandom_range(99);
        k = $urandom_range((n > 0 && n < STS_TABLE_DEPTH) ? n - 1 : STS_TABLE_DEPTH - 1);
        if (r < 50)
            return sb.keys[k];
        else if (r < 65)
            return sb.keys[k] + 1;
        else if (r < 80)
            return sb.keys[k] - 1;
        else if (r < 92)
            return $urandom();
        else if (r < 96)
            return '0;
        return 32'hFFFF_FFFF;
    endfunction

    task automatic run_round();
        int unsigned r, n, shape, len;
        r = $urandom_range(19);
        if (r < 2)
            n = 0;
        else if (r < 4)
            n = STS_TABLE_DEPTH;
        else if (r == 4)
            n = $urandom_range(31, STS_TABLE_DEPTH + 1);
        else
            n = $urandom_range(STS_TABLE_DEPTH, 1);
        set_entries(CNT_W'(n));
        shape = $urandom_range(9);
        if (shape == 0)
        begin
            for (int i = 0; i < STS_TABLE_DEPTH; i++)
                send_word(OP_WRITE, IDX_W'(i), $urandom());
        end
        else if (shape < 4)
            load_sorted(3);
        else if (shape < 6)
            load_sorted(32'h0000_FFFF);
        else
            load_sorted(32'h0FFF_FFFF);
        len = $urandom_range(32, 16);
        repeat (len)
        begin
            // an occasional stray write usually breaks the ordering
            if ($urandom_range(19) == 0)
                send_word(OP_WRITE, IDX_W'($urandom_range(15)), $urandom());
            else
                send_word(OP_SEARCH, IDX_W'($urandom_range(15)), pick_key(n));
        end
    endtask

    initial
    begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table before anything is written
        send_word(OP_SEARCH, '0, 32'h0000_0010);
        for (int i = 0; i < STS_TABLE_DEPTH; i++)
            send_word(OP_WRITE, IDX_W'(i), seed_keys[i]);
        set_entries(CNT_W'(STS_TABLE_DEPTH));
        send_word(OP_SEARCH, 4'hF, 32'h0000_0000);
        send_word(OP_SEARCH, '0, 32'hFFFF_FFFF);
        send_word(OP_SEARCH, '0, 32'h0000_0020);
        send_word(OP_SEARCH, '0, 32'h0000_0010);
        send_word(OP_SEARCH, '0, 32'h0000_1234);
        // count above the table depth clips to the depth
        set_entries(CNT_W'(31));
        send_word(OP_SEARCH, '0, 32'hFFFF_FFFE);
        set_entries(CNT_W'(1));
        send_word(OP_SEARCH, '0, 32'h0000_0010);
        send_word(OP_SEARCH, '0, 32'h0000_0011);
        set_entries('0);
        send_word(OP_SEARCH, '0, 32'h0000_0010);

        for (int phase = 0; phase < 4; phase++)
        begin
            unique case (phase)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 65; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 65;
                end
                default:
                begin
                    send_idle_pct = 19; recv_stall_pct = 19;
                end
            endcase
            for (int rnd = 0; rnd < 10; rnd++)
            begin
                if (phase == 0 && rnd == 2)
                begin
                    // long receiver hold-off so the input side backs up
                    drain();
                    fork
                        begin
                            hold_rx = 1'b1;
                            repeat (HOLD_CYCLES) @(negedge clk);
                            hold_rx = 1'b0;
                        end
                    join_none
                end
                run_round();
            end
        end

        drain();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sorted_table_binary_search.f =====
src/sts_pkg.sv
src/sts_ram.sv
src/sts_queue.sv
src/sts_front.sv
src/sts_back.sv
src/sorted_table_binary_search.sv
test/tb_top.sv
